FILE: rtl/pcdr_pkg.sv
// Shared types, codes and constants of the pointer click/drag/repeat core.
// No dependencies; every other file of the core refers to this package.
package pcdr_pkg;

    // Button count seen by the block and width of the held mask
    localparam int BTN_COUNT   = 8;
    localparam int HELD_BITS   = 8;
    localparam int IDX_W       = $clog2(HELD_BITS);
    // Highest button index that can auto-repeat
    localparam int SCAN_TOP    = ((BTN_COUNT < HELD_BITS) ? BTN_COUNT : HELD_BITS) - 1;

    localparam int POS_W  = 16;
    localparam int TIME_W = 20;
    localparam int DIST_W = 16;
    localparam int CIDX_W = 8;
    localparam int CDAT_W = 20;
    // Squared distance: two squares of a 17 bit difference
    localparam int SQ_W   = 33;
    localparam int D2_W   = SQ_W + 1;

    // Input operation codes
    localparam logic [1:0] OP_MOVE   = 2'd0;
    localparam logic [1:0] OP_BUTTON = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // Button action codes
    localparam logic [1:0] ACT_RELEASE = 2'd0;
    localparam logic [1:0] ACT_PRESS   = 2'd1;

    // Result kind codes
    localparam logic [1:0] KIND_MOVE    = 2'd0;
    localparam logic [1:0] KIND_PRESS   = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;
    localparam logic [1:0] KIND_DRAG    = 2'd3;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_REPEAT_INTERVAL = 8'd0;
    localparam logic [CIDX_W-1:0] CFG_DRAG_MIN_DIST   = 8'd1;

    // Result word sources selected by the controller
    localparam logic [2:0] EM_MOVE    = 3'd0;
    localparam logic [2:0] EM_PRESS   = 3'd1;
    localparam logic [2:0] EM_RELEASE = 3'd2;
    localparam logic [2:0] EM_DRAG    = 3'd3;
    localparam logic [2:0] EM_REPEAT  = 3'd4;

    localparam logic [TIME_W-1:0] REPEAT_INTERVAL_RST = 20'd100000;
    localparam logic [DIST_W-1:0] DRAG_MIN_DIST_RST   = 16'd25;

    typedef struct packed {
        logic [1:0]              op;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [7:0]              button_id;
        logic [1:0]              action;
        logic [TIME_W-1:0]       elapsed_us;
    } in_word_t;

    typedef struct packed {
        logic [1:0]              kind;
        logic [2:0]              which_button;
        logic signed [POS_W-1:0] cur_x;
        logic signed [POS_W-1:0] cur_y;
        logic signed [POS_W-1:0] start_x;
        logic signed [POS_W-1:0] start_y;
        logic                    last;
    } out_word_t;

    // Controller to datapath
    typedef struct packed {
        logic       capture;
        logic       tick;
        logic       mul;
        logic       emit;
        logic [2:0] emit_sel;
        logic       scan_adv;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic [1:0] action;
        logic       out_free;
        logic       expired;
        logic       drag;
        logic       scan_held;
        logic       scan_top;
    } dp_status_t;

endpackage

FILE: rtl/pcdr_ctrl.sv
// Sequencing state machine of the pointer core.
// Depends on pcdr_pkg; drives the datapath through dp_cmd_t, reads dp_status_t.
module pcdr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pcdr_pkg::dp_status_t sts,
    output pcdr_pkg::dp_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_DRAG = 3'd3;
    localparam logic [2:0] S_SCAN = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    // Decide next state and datapath commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.emit_sel = pcdr_pkg::EM_MOVE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DEC;
                end
            end
            S_DEC:
            begin
                case (sts.op)
                    pcdr_pkg::OP_MOVE:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.emit     = 1'b1;
                            cmd.emit_sel = pcdr_pkg::EM_MOVE;
                            state_next   = S_IDLE;
                        end
                    end
                    pcdr_pkg::OP_BUTTON:
                    begin
                        case (sts.action)
                            pcdr_pkg::ACT_PRESS:
                            begin
                                if (sts.out_free)
                                begin
                                    cmd.emit     = 1'b1;
                                    cmd.emit_sel = pcdr_pkg::EM_PRESS;
                                    state_next   = S_IDLE;
                                end
                            end
                            pcdr_pkg::ACT_RELEASE:
                            begin
                                cmd.mul    = 1'b1;
                                state_next = S_CMP;
                            end
                            default: state_next = S_IDLE;
                        endcase
                    end
                    pcdr_pkg::OP_TICK:
                    begin
                        cmd.tick   = 1'b1;
                        state_next = sts.expired ? S_SCAN : S_IDLE;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_CMP:
            begin
                if (sts.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = pcdr_pkg::EM_RELEASE;
                    state_next   = sts.drag ? S_DRAG : S_IDLE;
                end
            end
            S_DRAG:
            begin
                if (sts.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = pcdr_pkg::EM_DRAG;
                    state_next   = S_IDLE;
                end
            end
            S_SCAN:
            begin
                // Skip idle buttons, wait for the output slot on held ones
                if (!sts.scan_held || sts.out_free)
                begin
                    cmd.emit     = sts.scan_held;
                    cmd.emit_sel = pcdr_pkg::EM_REPEAT;
                    cmd.scan_adv = 1'b1;
                    if (sts.scan_top)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/pcdr_dp.sv
// Datapath of the pointer core: pointer state, timer, distance squares,
// button scan and the output register. Depends on pcdr_pkg.
module pcdr_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pcdr_pkg::in_word_t            in_data,
    input  logic                          cfg_valid,
    input  logic [pcdr_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [pcdr_pkg::CDAT_W-1:0]   cfg_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output pcdr_pkg::out_word_t           out_data,
    input  pcdr_pkg::dp_cmd_t             cmd,
    output pcdr_pkg::dp_status_t          sts
);

    pcdr_pkg::in_word_t                    item_reg;
    logic signed [pcdr_pkg::POS_W-1:0]     cursor_x_reg;
    logic signed [pcdr_pkg::POS_W-1:0]     cursor_y_reg;
    logic signed [pcdr_pkg::POS_W-1:0]     press_x_reg;
    logic signed [pcdr_pkg::POS_W-1:0]     press_y_reg;
    logic [pcdr_pkg::HELD_BITS-1:0]        held_reg;
    logic [pcdr_pkg::TIME_W-1:0]           wait_reg;
    logic [pcdr_pkg::TIME_W-1:0]           interval_reg;
    logic [pcdr_pkg::DIST_W-1:0]           drag_min_reg;
    logic [pcdr_pkg::SQ_W-1:0]             sqx_reg;
    logic [pcdr_pkg::SQ_W-1:0]             sqy_reg;
    logic [pcdr_pkg::IDX_W-1:0]            scan_idx_reg;
    logic                                  out_valid_reg;
    pcdr_pkg::out_word_t                   out_reg;
    pcdr_pkg::out_word_t                   out_next;

    logic [7:0]                            btn;
    logic [pcdr_pkg::HELD_BITS-1:0]        btn_bit;
    logic signed [pcdr_pkg::POS_W:0]       dx;
    logic signed [pcdr_pkg::POS_W:0]       dy;
    logic signed [2*pcdr_pkg::POS_W+1:0]   sqx;
    logic signed [2*pcdr_pkg::POS_W+1:0]   sqy;
    logic [pcdr_pkg::D2_W-1:0]             d2;
    logic                                  scan_last;
    logic                                  out_free;

    // Normalize the button number
    always_comb
    begin
        btn     = (item_reg.button_id < 8'(pcdr_pkg::BTN_COUNT)) ? item_reg.button_id : 8'd0;
        btn_bit = '0;
        if (btn < 8'(pcdr_pkg::HELD_BITS))
        begin
            btn_bit[btn[pcdr_pkg::IDX_W-1:0]] = 1'b1;
        end
    end

    // Square the press to cursor offsets
    assign dx  = {cursor_x_reg[pcdr_pkg::POS_W-1], cursor_x_reg}
               - {press_x_reg[pcdr_pkg::POS_W-1], press_x_reg};
    assign dy  = {cursor_y_reg[pcdr_pkg::POS_W-1], cursor_y_reg}
               - {press_y_reg[pcdr_pkg::POS_W-1], press_y_reg};
    assign sqx = dx * dx;
    assign sqy = dy * dy;
    assign d2  = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    // Look for held buttons above the scan index
    always_comb
    begin
        scan_last = 1'b1;
        for (int i = 1; i < pcdr_pkg::HELD_BITS; i++)
        begin
            if (i > int'(scan_idx_reg) && i <= pcdr_pkg::SCAN_TOP && held_reg[i])
            begin
                scan_last = 1'b0;
            end
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    // Report status to the controller
    always_comb
    begin
        sts           = '0;
        sts.op        = item_reg.op;
        sts.action    = item_reg.action;
        sts.out_free  = out_free;
        sts.expired   = !(wait_reg > item_reg.elapsed_us);
        sts.drag      = d2 >= pcdr_pkg::D2_W'(drag_min_reg);
        sts.scan_held = held_reg[scan_idx_reg];
        sts.scan_top  = scan_idx_reg == pcdr_pkg::IDX_W'(pcdr_pkg::SCAN_TOP);
    end

    // Build the result word
    always_comb
    begin
        out_next              = '0;
        out_next.cur_x        = cursor_x_reg;
        out_next.cur_y        = cursor_y_reg;
        out_next.which_button = btn[2:0];
        out_next.last         = 1'b1;
        case (cmd.emit_sel)
            pcdr_pkg::EM_MOVE:
            begin
                out_next.kind         = pcdr_pkg::KIND_MOVE;
                out_next.which_button = 3'd0;
                out_next.cur_x        = item_reg.pos_x;
                out_next.cur_y        = item_reg.pos_y;
            end
            pcdr_pkg::EM_PRESS:
            begin
                out_next.kind    = pcdr_pkg::KIND_PRESS;
                out_next.start_x = cursor_x_reg;
                out_next.start_y = cursor_y_reg;
            end
            pcdr_pkg::EM_RELEASE:
            begin
                out_next.kind = pcdr_pkg::KIND_RELEASE;
                out_next.last = !sts.drag;
            end
            pcdr_pkg::EM_DRAG:
            begin
                out_next.kind    = pcdr_pkg::KIND_DRAG;
                out_next.start_x = press_x_reg;
                out_next.start_y = press_y_reg;
            end
            pcdr_pkg::EM_REPEAT:
            begin
                out_next.kind         = pcdr_pkg::KIND_PRESS;
                out_next.which_button = 3'(scan_idx_reg);
                out_next.start_x      = cursor_x_reg;
                out_next.start_y      = cursor_y_reg;
                out_next.last         = scan_last;
            end
            default: out_next.kind = pcdr_pkg::KIND_MOVE;
        endcase
    end

    // Hold control state: cursor and press points, held mask, timer, scan index, output valid, config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg  <= '0;
            cursor_y_reg  <= '0;
            press_x_reg   <= '0;
            press_y_reg   <= '0;
            held_reg      <= '0;
            wait_reg      <= '0;
            interval_reg  <= pcdr_pkg::REPEAT_INTERVAL_RST;
            drag_min_reg  <= pcdr_pkg::DRAG_MIN_DIST_RST;
            scan_idx_reg  <= pcdr_pkg::IDX_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Take configuration writes
            if (cfg_valid)
            begin
                if (cfg_index == pcdr_pkg::CFG_REPEAT_INTERVAL)
                begin
                    interval_reg <= cfg_data;
                end
                else if (cfg_index == pcdr_pkg::CFG_DRAG_MIN_DIST)
                begin
                    drag_min_reg <= cfg_data[pcdr_pkg::DIST_W-1:0];
                end
            end
            // Update pointer state as results go out
            if (cmd.emit && cmd.emit_sel == pcdr_pkg::EM_MOVE)
            begin
                cursor_x_reg <= item_reg.pos_x;
                cursor_y_reg <= item_reg.pos_y;
            end
            if (cmd.emit && cmd.emit_sel == pcdr_pkg::EM_PRESS)
            begin
                press_x_reg <= cursor_x_reg;
                press_y_reg <= cursor_y_reg;
                wait_reg    <= interval_reg;
                held_reg    <= held_reg | btn_bit;
            end
            if (cmd.emit && cmd.emit_sel == pcdr_pkg::EM_RELEASE)
            begin
                held_reg <= held_reg & ~btn_bit;
            end
            // Count the timer down or reload it and restart the scan
            if (cmd.tick)
            begin
                wait_reg     <= sts.expired ? interval_reg : wait_reg - item_reg.elapsed_us;
                scan_idx_reg <= pcdr_pkg::IDX_W'(1);
            end
            if (cmd.scan_adv)
            begin
                scan_idx_reg <= scan_idx_reg + pcdr_pkg::IDX_W'(1);
            end
            // Output valid: set on emit, drop when taken
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_data;
        end
        if (cmd.mul)
        begin
            sqx_reg <= sqx[pcdr_pkg::SQ_W-1:0];
            sqy_reg <= sqy[pcdr_pkg::SQ_W-1:0];
        end
        if (cmd.emit)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

FILE: rtl/pointer_click_drag_repeat_core.sv
// Top level of the pointer click/drag/repeat core.
// Depends on pcdr_pkg, pcdr_ctrl and pcdr_dp.
//
//   channel | signals                              | dir | word
//   --------+--------------------------------------+-----+------------------------
//   in      | in_valid, in_ready, in_data          | in  | pcdr_pkg::in_word_t
//   out     | out_valid, out_ready, out_data       | out | pcdr_pkg::out_word_t
//   cfg     | cfg_valid, cfg_ready, cfg_index/data | in  | index 8 bit, data 20 bit
//
// One input word at a time: a word is accepted in idle and decoded in the next cycle.
// Move and press emit at decode; a release squares the offsets, emits the release
// and, past the drag threshold, a drag; an expired tick repeats held buttons 1..7.
// Results leave through a single output register; a stalled output stalls the
// controller, never drops a word. Reset clears pointer state and the timer and
// loads the default repeat interval and drag threshold. cfg_ready is always high.
module pointer_click_drag_repeat_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  pcdr_pkg::in_word_t          in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output pcdr_pkg::out_word_t         out_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [pcdr_pkg::CIDX_W-1:0] cfg_index,
    input  logic [pcdr_pkg::CDAT_W-1:0] cfg_data
);

    pcdr_pkg::dp_cmd_t    cmd;
    pcdr_pkg::dp_status_t sts;

    assign cfg_ready = 1'b1;

    // Sequence each input word
    pcdr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hold pointer state and build results
    pcdr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

FILE: rtl/pcdr_chk.sv
// Port-level checks of the pointer core, bound to the top level.
// Depends on pcdr_pkg.
module pcdr_chk (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input pcdr_pkg::out_word_t out_data
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // Drop input ready after taking a word
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while previous word in work");

    // A non-final result means the rest of the same word is still in work
    a_more: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last |-> !in_ready)
        else $error("input ready before final result");

    // Move and release results carry no start point
    a_no_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.kind == pcdr_pkg::KIND_MOVE
                      || out_data.kind == pcdr_pkg::KIND_RELEASE)
        |-> out_data.start_x == '0 && out_data.start_y == '0)
        else $error("start point set on move or release");

endmodule

bind pointer_click_drag_repeat_core pcdr_chk u_pcdr_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
